// ===== sv/mtfc_pkg.sv =====
// Package for the move-to-front handle cache.
// Field widths, entry and request types shared by the interfaces, cell and top level.
// No dependencies.
`default_nettype none

package mtfc_pkg;

  localparam int DEPTH_DEFAULT = 32;
  localparam int KEY_W         = 64;
  localparam int ANGLE_W       = 13;
  localparam int HANDLE_W      = 32;

  typedef struct packed {
    logic [KEY_W-1:0]          key;
    logic signed [ANGLE_W-1:0] angle;
  } lookup_t;

  typedef struct packed {
    logic                      valid;
    logic [KEY_W-1:0]          key;
    logic signed [ANGLE_W-1:0] angle;
    logic [HANDLE_W-1:0]       handle;
  } entry_t;

endpackage

`default_nettype wire

// ===== sv/mtfc_if.sv =====
// Request and result channel interfaces for the move-to-front handle cache.
// Depends on mtfc_pkg.
`default_nettype none

interface mtfc_req_if
  import mtfc_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic [KEY_W-1:0]          font_key;
  logic signed [ANGLE_W-1:0] angle;
  logic [HANDLE_W-1:0]       new_handle;

  modport source (output valid, font_key, angle, new_handle, input ready);
  modport sink   (input valid, font_key, angle, new_handle, output ready);
endinterface

interface mtfc_rsp_if
  import mtfc_pkg::*;
();
  logic                valid;
  logic                ready;
  logic                hit;
  logic [HANDLE_W-1:0] handle;
  logic                evict_valid;
  logic [HANDLE_W-1:0] evicted_handle;

  modport source (output valid, hit, handle, evict_valid, evicted_handle, input ready);
  modport sink   (input valid, hit, handle, evict_valid, evicted_handle, output ready);
endinterface

`default_nettype wire

// ===== sv/mtfc_cell.sv =====
// One list position of the move-to-front handle cache.
// Holds an entry, registers its match against a request, and loads from its front neighbor.
// Depends on mtfc_pkg.
`default_nettype none

module mtfc_cell
  import mtfc_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    cmp_en,
  input  wire lookup_t cmp,
  input  wire logic    upd_en,
  input  wire logic    found_in,
  input  wire entry_t  prev,
  output logic         found_out,
  output logic         first,
  output entry_t       entry
);

  logic   valid_r, valid_nxt;
  entry_t data_r;
  logic   match_r, match_nxt;
  logic   load;

  assign load      = upd_en & ~found_in;
  assign valid_nxt = load ? prev.valid : valid_r;
  assign match_nxt = valid_r & (data_r.key == cmp.key) & (data_r.angle == cmp.angle);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= prev;
    end
    if (cmp_en) begin
      match_r <= match_nxt;
    end
  end

  assign first     = match_r & ~found_in;
  assign found_out = found_in | match_r;

  always_comb begin
    entry       = data_r;
    entry.valid = valid_r;
  end

endmodule

`default_nettype wire

// ===== sv/move_to_front_handle_cache.sv =====
// Move-to-front handle cache: a row of DEPTH cells, position 0 at the front.
// On acceptance, every cell registers its key compare; in the update state that follows,
// the first match is resolved down the cell row, the row shifts and the result register
// loads. No new request is taken in the update state or while a result waits untaken.
// Reset (synchronous, rst_n low) marks all entries invalid and empties the result register.
// Depends on mtfc_pkg, mtfc_if and mtfc_cell.
`default_nettype none

module move_to_front_handle_cache
  import mtfc_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  mtfc_req_if.sink    in_req,
  mtfc_rsp_if.source  out_rsp
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_UPD  = 1'b1;

  logic state_r, state_nxt;
  logic accept;

  lookup_t             req_r;
  logic [HANDLE_W-1:0] new_handle_r;
  lookup_t             cmp;

  entry_t            cells   [DEPTH];
  entry_t            prev    [DEPTH];
  logic [DEPTH:0]    found;
  logic [DEPTH-1:0]  first;
  logic              upd_en;

  logic                hit;
  logic [HANDLE_W-1:0] hit_handle;
  entry_t              front;

  logic                out_valid_r, out_valid_nxt;
  logic                out_hit_r;
  logic [HANDLE_W-1:0] out_handle_r;
  logic                out_evict_r;
  logic [HANDLE_W-1:0] out_evicted_r;

  assign in_req.ready = (state_r == ST_IDLE) & (~out_valid_r | out_rsp.ready);
  assign accept       = in_req.valid & in_req.ready;
  assign upd_en       = (state_r == ST_UPD);

  assign cmp.key   = in_req.font_key;
  assign cmp.angle = in_req.angle;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_UPD;
      ST_UPD:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r        <= cmp;
      new_handle_r <= in_req.new_handle;
    end
  end

  assign found[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_front
      assign prev[i] = front;
    end else begin : g_rest
      assign prev[i] = cells[i-1];
    end

    mtfc_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmp_en    (accept),
      .cmp       (cmp),
      .upd_en    (upd_en),
      .found_in  (found[i]),
      .prev      (prev[i]),
      .found_out (found[i+1]),
      .first     (first[i]),
      .entry     (cells[i])
    );
  end

  assign hit = found[DEPTH];

  always_comb begin
    hit_handle = '0;
    for (int i = 0; i < DEPTH; i++) begin
      hit_handle = hit_handle | ({HANDLE_W{first[i]}} & cells[i].handle);
    end
  end

  always_comb begin
    front.valid  = 1'b1;
    front.key    = req_r.key;
    front.angle  = req_r.angle;
    front.handle = hit ? hit_handle : new_handle_r;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_rsp.ready) out_valid_nxt = 1'b0;
    if (upd_en) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_en) begin
      out_hit_r     <= hit;
      out_handle_r  <= front.handle;
      out_evict_r   <= ~hit & cells[DEPTH-1].valid;
      out_evicted_r <= (~hit & cells[DEPTH-1].valid) ? cells[DEPTH-1].handle : '0;
    end
  end

  assign out_rsp.valid          = out_valid_r;
  assign out_rsp.hit            = out_hit_r;
  assign out_rsp.handle         = out_handle_r;
  assign out_rsp.evict_valid    = out_evict_r;
  assign out_rsp.evicted_handle = out_evicted_r;

endmodule

`default_nettype wire

// ===== test/mtfc_lookup_checker.sv =====
// Lookup checker for the move-to-front handle cache: predicts each result from
// the requests that it sees and compares every result field against that prediction.
// Depends on mtfc_pkg and mtfc_if.
`default_nettype none

module mtfc_lookup_checker
  import mtfc_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  wire logic clk,
  input  wire logic rst_n,
  mtfc_req_if       req,
  mtfc_rsp_if       rsp,
  output int        n_errors,
  output int        n_pending,
  output int        n_checked,
  output int        n_hits,
  output int        n_evicts
);

  typedef struct packed {
    logic                hit;
    logic [HANDLE_W-1:0] handle;
    logic                evict_valid;
    logic [HANDLE_W-1:0] evicted_handle;
  } lookup_result_t;

  entry_t         mtf_row [DEPTH];
  lookup_result_t pending_results [$];
  int             mismatches;
  int             checked;
  int             hits;
  int             evicts;

  function automatic lookup_result_t lookup_and_promote(
    input logic [KEY_W-1:0]          key,
    input logic signed [ANGLE_W-1:0] angle,
    input logic [HANDLE_W-1:0]       fresh_handle
  );
    int             pos;
    int             last;
    lookup_result_t res;
    pos = -1;
    for (int i = 0; i < DEPTH; i++) begin
      if (pos < 0 && mtf_row[i].valid && mtf_row[i].key == key && mtf_row[i].angle == angle)
        pos = i;
    end
    if (pos >= 0) begin
      res.hit            = 1'b1;
      res.handle         = mtf_row[pos].handle;
      res.evict_valid    = 1'b0;
      res.evicted_handle = '0;
      last               = pos;
    end else begin
      res.hit            = 1'b0;
      res.handle         = fresh_handle;
      res.evict_valid    = mtf_row[DEPTH-1].valid;
      res.evicted_handle = mtf_row[DEPTH-1].valid ? mtf_row[DEPTH-1].handle : '0;
      last               = DEPTH - 1;
    end
    for (int i = last; i > 0; i--)
      mtf_row[i] = mtf_row[i-1];
    mtf_row[0] = '{valid: 1'b1, key: key, angle: angle, handle: res.handle};
    return res;
  endfunction

  task automatic compare_field(input string name, input logic [HANDLE_W-1:0] want,
                               input logic [HANDLE_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    lookup_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++)
        mtf_row[i] = '0;
      pending_results.delete();
      mismatches = 0;
      checked    = 0;
      hits       = 0;
      evicts     = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (pending_results.size() == 0) begin
          $error("result arrived with no request outstanding");
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          compare_field("hit", want.hit, rsp.hit);
          compare_field("handle", want.handle, rsp.handle);
          compare_field("evict_valid", want.evict_valid, rsp.evict_valid);
          compare_field("evicted_handle", want.evicted_handle, rsp.evicted_handle);
          checked++;
          if (want.hit)
            hits++;
          if (want.evict_valid)
            evicts++;
        end
      end
      if (req.valid && req.ready)
        pending_results.push_back(lookup_and_promote(req.font_key, req.angle, req.new_handle));
    end
    n_errors  <= mismatches;
    n_pending <= pending_results.size();
    n_checked <= checked;
    n_hits    <= hits;
    n_evicts  <= evicts;
  end

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// Top-level testbench for the move-to-front handle cache: clock, reset, request
// stimulus and result back-pressure, with the verdict taken from the lookup checker.
// Depends on mtfc_pkg, mtfc_if, mtfc_lookup_checker and move_to_front_handle_cache.
`default_nettype none

module tb;
  import mtfc_pkg::*;

  localparam int DEPTH            = DEPTH_DEFAULT;
  localparam int RANDOM_ITEMS     = 750;
  localparam int POOL_SIZE        = 48;
  localparam int BASE_KEYS        = 30;
  localparam int LONG_HOLD_CYCLES = 200;

  logic clk;
  logic rst_n;
  int   n_errors;
  int   n_pending;
  int   n_checked;
  int   n_hits;
  int   n_evicts;
  int   n_sent;
  logic no_idle;
  logic hold_off_rsp;
  logic long_hold_done;

  logic [KEY_W-1:0]          base_key   [BASE_KEYS];
  logic [KEY_W-1:0]          pool_key   [POOL_SIZE];
  logic signed [ANGLE_W-1:0] pool_angle [POOL_SIZE];

  mtfc_req_if req_ch ();
  mtfc_rsp_if rsp_ch ();

  move_to_front_handle_cache #(.DEPTH(DEPTH)) u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_ch),
    .out_rsp (rsp_ch)
  );

  mtfc_lookup_checker #(.DEPTH(DEPTH)) u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .n_errors  (n_errors),
    .n_pending (n_pending),
    .n_checked (n_checked),
    .n_hits    (n_hits),
    .n_evicts  (n_evicts)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

  task automatic send_lookup(input logic [KEY_W-1:0] key,
                             input logic signed [ANGLE_W-1:0] angle,
                             input logic [HANDLE_W-1:0] fresh_handle);
    req_ch.valid      <= 1'b1;
    req_ch.font_key   <= key;
    req_ch.angle      <= angle;
    req_ch.new_handle <= fresh_handle;
    do @(posedge clk); while (!req_ch.ready);
    n_sent++;
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  function automatic logic [HANDLE_W-1:0] random_handle();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Receiver: random ready bursts, one long hold-off on request.
  initial begin
    rsp_ch.ready   <= 1'b0;
    long_hold_done = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_off_rsp && !long_hold_done) begin
        long_hold_done = 1'b1;
        rsp_ch.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
      end else if (!no_idle && $urandom_range(0, 3) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end else begin
        rsp_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  initial begin
    int                        span;
    int                        idx;
    logic [KEY_W-1:0]          key;
    logic signed [ANGLE_W-1:0] angle;

    rst_n             <= 1'b0;
    req_ch.valid      <= 1'b0;
    req_ch.font_key   <= '0;
    req_ch.angle      <= '0;
    req_ch.new_handle <= '0;
    no_idle           <= 1'b0;
    hold_off_rsp      <= 1'b0;
    n_sent            = 0;
    span              = POOL_SIZE;

    for (int i = 0; i < BASE_KEYS; i++)
      base_key[i] = {$urandom, $urandom};
    for (int i = 0; i < POOL_SIZE; i++) begin
      pool_key[i] = base_key[i % BASE_KEYS];
      if (i < BASE_KEYS)
        pool_angle[i] = ANGLE_W'($urandom_range(0, 4) * 900 - 1800);
      else
        pool_angle[i] = ANGLE_W'($urandom);
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty cache, then a hit on the same key
    send_lookup(64'h0, 13'sd0, 32'h0);
    send_lookup(64'h0, 13'sd0, 32'h5);
    // extremes of key, angle and handle; same key with another angle
    send_lookup('1, -13'sd3600, 32'hFFFF_FFFF);
    send_lookup('1, 13'sd3600, 32'h1);
    send_lookup('1, -13'sd3600, 32'h2);
    send_lookup(64'h0, 13'sd0, 32'h3);
    // raw angles outside the legal range
    send_lookup(64'h1, 13'h1000, 32'h8000_0000);
    send_lookup(64'h1, 13'h0FFF, 32'h7FFF_FFFF);
    send_lookup(64'h1, 13'h1000, 32'h0);
    send_lookup(64'h8000_0000_0000_0000, -13'sd1, 32'h8000_0000);
    send_lookup(64'h8000_0000_0000_0000, 13'sd1, 32'h0);
    send_lookup(64'h7FFF_FFFF_FFFF_FFFF, -13'sd1, 32'hAAAA_5555);
    send_lookup(64'h8000_0000_0000_0000, -13'sd1, 32'h1234_5678);
    send_lookup('1, 13'sd3600, 32'h0);
    send_lookup(64'h1, 13'h0FFF, 32'h0);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 60 == 0)
        case ($urandom_range(0, 3))
          0:       span = 4;
          1:       span = 20;
          2:       span = 34;
          default: span = POOL_SIZE;
        endcase
      if (n == 250)
        hold_off_rsp <= 1'b1;
      if (n == RANDOM_ITEMS - 100)
        no_idle <= 1'b1;
      if ($urandom_range(0, 9) < 8) begin
        idx   = $urandom_range(0, span - 1);
        key   = pool_key[idx];
        angle = pool_angle[idx];
      end else begin
        key   = {$urandom, $urandom};
        angle = ANGLE_W'($urandom_range(0, 7200) - 3600);
      end
      send_lookup(key, angle, random_handle());
    end

    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (n_pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d lookups, checked %0d results: %0d hits, %0d evictions of valid entries.",
             n_sent, n_checked, n_hits, n_evicts);
    if (n_errors == 0 && n_pending == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

`default_nettype wire

// ===== move_to_front_handle_cache.f =====
sv/mtfc_pkg.sv
sv/mtfc_if.sv
sv/mtfc_cell.sv
sv/move_to_front_handle_cache.sv
test/mtfc_lookup_checker.sv
test/tb.sv
